// ===== design/wto_pkg.sv =====
// Shared types and constants of the wavetable oscillator.
package wto_pkg;

  localparam int TABLE_DEPTH_DEF  = 1024;
  localparam int INDEX_SHIFT_DEF  = 22;
  localparam int SAMPLE_WIDTH_DEF = 16;

  localparam int PHASE_W  = 32;
  localparam int INDEX_W  = 10;
  localparam int VALUE_W  = 16;
  localparam int MOD_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_TICK  = 1'b1
  } op_t;

  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MOD_ENABLE = 2'd1;

endpackage

// ===== design/wto_if.sv =====
// Channel interfaces of the wavetable oscillator: item input, sample output, register writes.
interface wto_in_if;
  logic                                valid;
  logic                                ready;
  logic                                op;
  logic [wto_pkg::INDEX_W-1:0]         table_index;
  logic signed [wto_pkg::VALUE_W-1:0]  table_value;
  logic signed [wto_pkg::MOD_W-1:0]    mod_value;

  modport source (output valid, op, table_index, table_value, mod_value, input ready);
  modport sink   (input valid, op, table_index, table_value, mod_value, output ready);
endinterface

interface wto_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [wto_pkg::VALUE_W-1:0]  sample;

  modport source (output valid, sample, input ready);
  modport sink   (input valid, sample, output ready);
endinterface

interface wto_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [wto_pkg::CFG_IDX_W-1:0]       index;
  logic [wto_pkg::CFG_DATA_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/wavetable_oscillator.sv =====
// Wavetable oscillator top level: phase pipeline around the wave table RAM.
//
// Channels: in_s takes items (op write: store table_value at table_index;
// op tick: emit the sample at the current phase and advance the phase).
// out_s returns one sample per tick, none per write. cfg_s writes
// phase_step (index 0) and mod_enable (index 1); it is always ready and
// must only be used while no tick is in flight.
// Throughput: one item per cycle while out_s does not stall, writes and
// ticks freely mixed. The phase register is the only loop: one add per
// tick, with the multiply for the modulated step done two stages ahead of it.
// A tick's sample is registered in the product, increment, phase and address
// stages, then in the RAM read register. A write passes the same stages and
// lands in the RAM as it leaves the address stage, ahead of any later tick.
// Reset: clears phase, configuration and all stage valids. The table is
// not cleared; entries are undefined until written.
// Stall: the RAM read register holds the sample while out_s.ready is low;
// stages behind it keep filling bubbles, and in_s.ready drops only when
// every stage holds an item.
module wavetable_oscillator #(
  parameter int TABLE_DEPTH  = wto_pkg::TABLE_DEPTH_DEF,
  parameter int INDEX_SHIFT  = wto_pkg::INDEX_SHIFT_DEF,
  parameter int SAMPLE_WIDTH = wto_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  wto_in_if.sink    in_s,
  wto_out_if.source out_s,
  wto_cfg_if.sink   cfg_s
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int VW = wto_pkg::PHASE_W - INDEX_SHIFT;  // phase bits above the shift
  localparam int K  = VW + AW;
  localparam int MW = VW + 1;
  localparam int PW = VW + MW;
  localparam int RW = VW + AW + 1;
  localparam longint unsigned RECIP_L = (64'd1 << K) / TABLE_DEPTH;
  localparam logic [MW-1:0] RECIP     = MW'(RECIP_L);
  localparam logic [RW-1:0] DEPTH_R   = RW'(TABLE_DEPTH);

  typedef struct packed {
    logic                    op;
    logic                    wr_ok;
    logic [AW-1:0]           widx;
    logic [SAMPLE_WIDTH-1:0] wval;
  } item_t;

  // configuration
  logic [31:0] phase_step_r;
  logic        mod_enable_r;

  // stage valids and items
  logic  v1_r, v2_r, v3_r, v4_r, out_v_r;
  item_t it1_r, it2_r, it3_r, it4_r;
  logic signed [47:0] prod_r;
  logic [31:0]        inc_r;
  logic [31:0]        phase_r;
  logic [VW-1:0]      vph3_r, vph4_r;
  logic [PW-1:0]      mul4_r;

  logic  go4, free1, free2, free3, free4;
  item_t it_in;
  logic [16:0] idx_ext;
  logic [23:0] val_ext;
  logic signed [47:0] prod_nxt;
  logic signed [47:0] biased;
  logic [31:0] inc_nxt;
  logic [VW-1:0] quo;
  logic [RW-1:0] qd, rem0, rem;
  logic [AW-1:0] raddr;
  logic          ram_we, ram_re;
  logic [SAMPLE_WIDTH-1:0] rdata;
  logic [23:0]   rd_ext;

  assign cfg_s.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r <= '0;
      mod_enable_r <= 1'b0;
    end else if (cfg_s.valid) begin
      case (cfg_s.index)
        wto_pkg::CFG_PHASE_STEP: phase_step_r <= cfg_s.data;
        wto_pkg::CFG_MOD_ENABLE: mod_enable_r <= cfg_s.data[0];
        default: ;
      endcase
    end
  end

  // stage handshakes: a stage loads when empty or when its item moves on
  assign go4   = v4_r && (it4_r.op == wto_pkg::OP_WRITE || !out_v_r || out_s.ready);
  assign free4 = !v4_r || go4;
  assign free3 = !v3_r || free4;
  assign free2 = !v2_r || free3;
  assign free1 = !v1_r || free2;
  assign in_s.ready = free1;

  always_comb begin
    idx_ext     = {7'b0, in_s.table_index};
    val_ext     = {8'b0, in_s.table_value};
    it_in.op    = in_s.op;
    it_in.wr_ok = (32'(in_s.table_index) < TABLE_DEPTH);
    it_in.widx  = idx_ext[AW-1:0];
    it_in.wval  = val_ext[SAMPLE_WIDTH-1:0];
    prod_nxt    = 48'($signed(phase_step_r)) * 48'(in_s.mod_value);
  end

  // Q4.12 scaling, truncated toward zero
  always_comb begin
    biased  = prod_r + (prod_r[47] ? 48'sd4095 : 48'sd0);
    inc_nxt = mod_enable_r ? (phase_step_r + biased[43:12]) : phase_step_r;
  end

  // table address = phase index mod depth, by reciprocal and one correction
  always_comb begin
    quo  = VW'(mul4_r >> K);
    qd   = RW'(quo) * DEPTH_R;
    rem0 = RW'(vph4_r) - qd;
    rem  = (rem0 >= DEPTH_R) ? (rem0 - DEPTH_R) : rem0;
    raddr = rem[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      out_v_r <= 1'b0;
      phase_r <= '0;
    end else begin
      if (free1) v1_r <= in_s.valid;
      if (free2) v2_r <= v1_r;
      if (free3) v3_r <= v2_r;
      if (free4) v4_r <= v3_r;
      if (go4 && it4_r.op == wto_pkg::OP_TICK) begin
        out_v_r <= 1'b1;
      end else if (out_s.ready) begin
        out_v_r <= 1'b0;
      end
      if (free3 && v2_r && it2_r.op == wto_pkg::OP_TICK) begin
        phase_r <= phase_r + inc_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (free1) begin
      it1_r  <= it_in;
      prod_r <= prod_nxt;
    end
    if (free2) begin
      it2_r <= it1_r;
      inc_r <= inc_nxt;
    end
    if (free3) begin
      it3_r  <= it2_r;
      vph3_r <= phase_r[31:INDEX_SHIFT];
    end
    if (free4) begin
      it4_r  <= it3_r;
      vph4_r <= vph3_r;
      mul4_r <= PW'(vph3_r) * PW'(RECIP);
    end
  end

  assign ram_we = go4 && it4_r.op == wto_pkg::OP_WRITE && it4_r.wr_ok;
  assign ram_re = go4 && it4_r.op == wto_pkg::OP_TICK;

  wto_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (it4_r.widx),
    .wdata (it4_r.wval),
    .re    (ram_re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_ext       = 24'(rdata);
  assign out_s.valid  = out_v_r;
  assign out_s.sample = rd_ext[15:0];

endmodule

// ===== design/wto_ram.sv =====
// Generic simple dual-port RAM, one write port, one registered read port.
module wto_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== dv/wavetable_oscillator_test.sv =====
// Self-checking testbench for the wavetable oscillator: table writes, flat and modulated ticks.
module wavetable_oscillator_test;
  import wto_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RANDOM_ITEMS  = 950;
  localparam int PHASE_COUNT   = 8;
  localparam int SETTLE_CYCLES = 10;
  localparam int DEPTH         = TABLE_DEPTH_DEF;
  localparam int SHIFT         = INDEX_SHIFT_DEF;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t                     kind;
    op_t                           op;
    logic [INDEX_W-1:0]            index;
    logic signed [VALUE_W-1:0]     value;
    logic signed [MOD_W-1:0]       mod;
    bit                            typed;
    logic signed [VALUE_W-1:0]     sample;
    logic [CFG_IDX_W-1:0]          reg_idx;
    logic [CFG_DATA_W-1:0]         reg_data;
  } stim_row_t;

  logic clk;
  logic rst_n;

  wto_in_if  in_ch ();
  wto_out_if out_ch ();
  wto_cfg_if cfg_ch ();

  wavetable_oscillator uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_ch),
    .out_s (out_ch),
    .cfg_s (cfg_ch)
  );

  // oscillator shadow state
  logic [PHASE_W-1:0]        phase_acc;
  logic [PHASE_W-1:0]        step_reg;
  bit                        mod_on;
  logic signed [VALUE_W-1:0] wave_mem [DEPTH];
  bit                        loaded [DEPTH];
  logic signed [VALUE_W-1:0] sample_queue [$];

  bit          gaps_on = 1'b1;
  int unsigned mismatches = 0;
  int unsigned samples_checked = 0;
  int unsigned items_sent = 0;
  int unsigned fills_sent = 0;
  int unsigned reg_writes = 0;
  int unsigned cycle_count = 0;

  stim_row_t directed [$];

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("wavetable_oscillator_test NOT OK");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic stim_row_t item_row(op_t op, int idx, int val, int mod,
                                         bit typed = 1'b0, int sample = 0);
    stim_row_t r;
    r.kind     = ROW_ITEM;
    r.op       = op;
    r.index    = idx[INDEX_W-1:0];
    r.value    = val[VALUE_W-1:0];
    r.mod      = mod[MOD_W-1:0];
    r.typed    = typed;
    r.sample   = sample[VALUE_W-1:0];
    r.reg_idx  = '0;
    r.reg_data = '0;
    return r;
  endfunction

  function automatic stim_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    stim_row_t r;
    r.kind     = ROW_REG;
    r.op       = OP_WRITE;
    r.index    = '0;
    r.value    = '0;
    r.mod      = '0;
    r.typed    = 1'b0;
    r.sample   = '0;
    r.reg_idx  = idx;
    r.reg_data = data;
    return r;
  endfunction

  function automatic logic [INDEX_W-1:0] table_addr(logic [PHASE_W-1:0] ph);
    return INDEX_W'((ph >> SHIFT) % DEPTH);
  endfunction

  // step plus step * mod / 4096, quotient truncated toward zero, wraps at 32 bits
  function automatic logic [PHASE_W-1:0] phase_increment(logic [PHASE_W-1:0] step, bit modulate,
                                                         logic signed [MOD_W-1:0] m);
    longint s;
    longint prod;
    longint q;
    if (!modulate) return step;
    s    = longint'(signed'(step));
    prod = s * longint'(m);
    q    = prod / 64'sd4096;
    return step + q[PHASE_W-1:0];
  endfunction

  function automatic logic signed [VALUE_W-1:0] random_value();
    case ($urandom_range(0, 9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'sh0000;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [MOD_W-1:0] random_mod();
    case ($urandom_range(0, 19))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'sh0000;
      3:       return 16'sh1000;
      4:       return -16'sh1000;
      5:       return -16'sh0001;
      default: return MOD_W'($urandom);
    endcase
  endfunction

  // update the shadow state once an item has transferred
  function automatic void record_item(stim_row_t r);
    logic signed [VALUE_W-1:0] predicted;
    if (r.op == OP_WRITE) begin
      wave_mem[r.index] = r.value;
      loaded[r.index]   = 1'b1;
    end else begin
      predicted = r.typed ? r.sample : wave_mem[table_addr(phase_acc)];
      sample_queue.push_back(predicted);
      phase_acc = phase_acc + phase_increment(step_reg, mod_on, r.mod);
    end
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic drive_item(stim_row_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       = 1'b1;
    in_ch.op          = r.op;
    in_ch.table_index = r.index;
    in_ch.table_value = r.value;
    in_ch.mod_value   = r.mod;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    record_item(r);
    items_sent++;
    @(negedge clk);
  endtask

  // a tick must never read an entry that was never loaded: load it first
  task automatic send_item(stim_row_t r);
    logic [INDEX_W-1:0] addr;
    addr = table_addr(phase_acc);
    if (r.op == OP_TICK && !loaded[addr]) begin
      drive_item(item_row(OP_WRITE, addr, random_value(), 0));
      fills_sent++;
    end
    drive_item(r);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    in_ch.valid = 1'b0;
    while (sample_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = data;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    if (idx == CFG_PHASE_STEP) step_reg = data;
    else if (idx == CFG_MOD_ENABLE) mod_on = data[0];
    reg_writes++;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // output side stalls
  initial begin
    int hold;
    forever begin
      hold = pick_gap();
      if (hold > 0) begin
        out_ch.ready = 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    logic signed [VALUE_W-1:0] want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (sample_queue.size() == 0) begin
        $error("sample: expected none, got %0d", out_ch.sample);
        mismatches++;
      end else begin
        want = sample_queue.pop_front();
        samples_checked++;
        if (out_ch.sample !== want) begin
          $error("sample: expected %0d, got %0d", want, out_ch.sample);
          mismatches++;
        end
      end
    end
  end

  initial begin
    stim_row_t             r;
    logic [CFG_DATA_W-1:0] step_sel;
    bit                    mod_sel;
    int                    per_phase;
    int                    burst;
    int unsigned           phase_end;

    in_ch.valid       = 1'b0;
    in_ch.op          = OP_WRITE;
    in_ch.table_index = '0;
    in_ch.table_value = '0;
    in_ch.mod_value   = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = CFG_PHASE_STEP;
    cfg_ch.data       = '0;
    rst_n             = 1'b0;

    phase_acc = '0;
    step_reg  = '0;
    mod_on    = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      loaded[i]   = 1'b0;
      wave_mem[i] = '0;
    end

    // phase 0, step 0 after reset: ticks stay on entry 0
    directed.push_back(item_row(OP_WRITE, 0, 32767, 0));
    directed.push_back(item_row(OP_TICK, 0, 0, 0, 1'b1, 32767));
    directed.push_back(item_row(OP_WRITE, 0, -32768, 0));
    directed.push_back(item_row(OP_TICK, 0, 0, 0, 1'b1, -32768));
    directed.push_back(item_row(OP_WRITE, 1023, 16'h5555, 0));
    directed.push_back(item_row(OP_WRITE, 512, -1, 0));
    directed.push_back(item_row(OP_WRITE, 1, -21846, 32767));
    // step of minus one entry: phase wraps down to the top entry
    directed.push_back(reg_row(CFG_PHASE_STEP, 32'hFFC0_0000));
    // flat rate ignores the modulation value
    directed.push_back(item_row(OP_TICK, 0, 0, 32767, 1'b1, -32768));
    directed.push_back(item_row(OP_TICK, 0, 0, -32768, 1'b1, 16'sh5555));
    directed.push_back(reg_row(CFG_PHASE_STEP, 32'h8000_0000));
    directed.push_back(item_row(OP_TICK, 0, 0, -32768));
    directed.push_back(reg_row(CFG_MOD_ENABLE, 32'd1));
    // most negative step times most negative factor: product wraps out
    directed.push_back(item_row(OP_TICK, 0, 0, -32768));
    directed.push_back(item_row(OP_TICK, 0, 0, 32767));
    // step of -1: small factors truncate toward zero
    directed.push_back(reg_row(CFG_PHASE_STEP, 32'hFFFF_FFFF));
    directed.push_back(item_row(OP_TICK, 0, 0, 4095));
    directed.push_back(item_row(OP_TICK, 0, 0, -4097));
    directed.push_back(item_row(OP_TICK, 0, 0, -32768));
    directed.push_back(reg_row(CFG_PHASE_STEP, 32'h0040_0000));
    directed.push_back(item_row(OP_TICK, 0, 0, 4096));
    directed.push_back(item_row(OP_TICK, 0, 0, -4096));
    directed.push_back(item_row(OP_WRITE, 700, 32767, 0));
    directed.push_back(item_row(OP_TICK, 0, 0, 0));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_REG) write_register(directed[i].reg_idx, directed[i].reg_data);
      else send_item(directed[i]);
    end

    per_phase = RANDOM_ITEMS / PHASE_COUNT;
    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0: begin step_sel = 32'hFFFF_FFFF; mod_sel = 1'b1; end
        1: begin step_sel = 32'h0000_0000; mod_sel = 1'b0; end
        2: begin step_sel = $urandom_range(1, 1 << 24); mod_sel = 1'b1; end
        3: begin step_sel = $urandom; mod_sel = 1'b0; end
        4: begin step_sel = 32'h8000_0000; mod_sel = 1'b1; end
        5: begin step_sel = 32'h0040_0000; mod_sel = 1'b0; end
        6: begin step_sel = 32'h7FFF_FFFF; mod_sel = 1'b1; end
        default: begin step_sel = $urandom; mod_sel = 1'b1; end
      endcase
      gaps_on = (p % 3 != 1);
      write_register(CFG_PHASE_STEP, step_sel);
      write_register(CFG_MOD_ENABLE, {31'd0, mod_sel});
      // entry loads ahead of ticks count toward the phase's share
      phase_end = items_sent + per_phase;
      while (items_sent < phase_end) begin
        // occasional runs of consecutive table loads
        burst = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 12) : 1;
        for (int k = 0; k < burst; k++) begin
          if (burst == 1 && $urandom_range(0, 99) < 60)
            r = item_row(OP_TICK, $urandom_range(0, DEPTH - 1), random_value(), random_mod());
          else
            r = item_row(OP_WRITE, $urandom_range(0, DEPTH - 1), random_value(), random_mod());
          send_item(r);
        end
      end
    end

    in_ch.valid = 1'b0;
    while (sample_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d items (%0d entry loads ahead of ticks), %0d register writes.",
             items_sent, fills_sent, reg_writes);
    $display("Checked %0d samples over %0d step/modulation settings.",
             samples_checked, PHASE_COUNT + 6);
    if (mismatches == 0 && sample_queue.size() == 0) begin
      $display("wavetable_oscillator_test OK");
    end else begin
      $display("wavetable_oscillator_test NOT OK");
    end
    $finish;
  end

endmodule

// ===== wavetable_oscillator.f =====
design/wto_pkg.sv
design/wto_if.sv
design/wto_ram.sv
design/wavetable_oscillator.sv
dv/wavetable_oscillator_test.sv
